[hdl/bbc_pkg.sv]
// bbc_pkg: types, codes and bracket decode helpers for the bracket balance checker
// no dependencies; imported by the channel interfaces, the top level and the checker
`default_nettype none

package bbc_pkg;

   // default stack capacity in entries
   localparam int DEFAULT_STACK_DEPTH = 128;

   localparam int CHAR_W   = 8;
   localparam int REASON_W = 3;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [1:0]        kind_type;

   // verdict reason codes
   typedef enum logic [REASON_W-1:0] {
      REASON_OK       = 3'd0,
      REASON_EMPTY    = 3'd1,
      REASON_MISMATCH = 3'd2,
      REASON_UNCLOSED = 3'd3,
      REASON_OVERFLOW = 3'd4
   } reason_type;

   // bracket kinds
   localparam kind_type KIND_ROUND  = 2'd0;
   localparam kind_type KIND_SQUARE = 2'd1;
   localparam kind_type KIND_CURLY  = 2'd2;
   localparam kind_type KIND_NONE   = 2'd3;

   // character codes
   localparam char_type CHAR_END       = 8'h00;
   localparam char_type CHAR_OPEN_RND  = 8'h28;
   localparam char_type CHAR_CLOSE_RND = 8'h29;
   localparam char_type CHAR_OPEN_SQR  = 8'h5B;
   localparam char_type CHAR_CLOSE_SQR = 8'h5D;
   localparam char_type CHAR_OPEN_CRL  = 8'h7B;
   localparam char_type CHAR_CLOSE_CRL = 8'h7D;

   // kind of an opening bracket, or none
   function automatic kind_type open_kind(input char_type c);
      kind_type k;
      case (c)
         CHAR_OPEN_RND: k = KIND_ROUND;
         CHAR_OPEN_SQR: k = KIND_SQUARE;
         CHAR_OPEN_CRL: k = KIND_CURLY;
         default:       k = KIND_NONE;
      endcase
      return k;
   endfunction

   // kind of a closing bracket, or none
   function automatic kind_type close_kind(input char_type c);
      kind_type k;
      case (c)
         CHAR_CLOSE_RND: k = KIND_ROUND;
         CHAR_CLOSE_SQR: k = KIND_SQUARE;
         CHAR_CLOSE_CRL: k = KIND_CURLY;
         default:        k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

[hdl/bbc_channels.sv]
// bbc_req_if and bbc_rsp_if: valid/ready channels of the bracket balance checker
// depends on bbc_pkg for payload widths
`default_nettype none

interface bbc_req_if;
   import bbc_pkg::*;

   logic     valid;
   logic     ready;
   char_type character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface bbc_rsp_if;
   import bbc_pkg::*;

   logic                valid;
   logic                ready;
   logic                balanced;
   logic [REASON_W-1:0] reason;

   modport source (output valid, output balanced, output reason, input ready);
   modport sink   (input valid, input balanced, input reason, output ready);
endinterface

`default_nettype wire

[hdl/bracket_balance_checker.sv]
// bracket_balance_checker: top level, stack of bracket kinds in a synchronous memory
// depends on bbc_pkg and the channel interfaces in bbc_channels.sv
//
// usage:
//   req_chan carries one character byte per transfer. opening brackets push their
//   kind, closing brackets pop and compare, other bytes are ignored. after the first
//   error the rest of the string is ignored. a zero byte ends the string.
//   rsp_chan carries one verdict (balanced, reason) per zero byte, and nothing else.
//   throughput: one byte per cycle if not stalled. the stack memory has one write and
//   one read port; the read for the next top is issued at the end of every cycle,
//   and a kind pushed in the previous cycle is taken from a forwarding register.
//   the verdict shows on rsp_chan in the cycle after the zero byte transfer.
//   the verdict sits in an output register; while it waits, req_chan.ready is low
//   unless rsp_chan.ready is high, so a stalled receiver stalls the sender and
//   nothing is lost. with rsp_chan.ready high the block takes a byte every cycle.
//   reset (synchronous, active high) empties the stack and clears the error and
//   the output valid flag; stack memory contents need no clearing.
`default_nettype none

module bracket_balance_checker #(
   parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
   input  wire     clock,
   input  wire     reset,
   bbc_req_if.sink   req_chan,
   bbc_rsp_if.source rsp_chan
);
   import bbc_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   // stack memory
   kind_type stack_mem [STACK_DEPTH];

   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [CNT_W-1:0]  depth_dec;
   logic [ADDR_W-1:0] rd_addr;
   reason_type        error_ff, error_in;
   kind_type          rd_kind_ff;
   logic              fwd_ff, fwd_in;
   kind_type          fwd_kind_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   reason_type        rsp_reason_ff, rsp_reason_in;

   logic     req_ready;
   logic     accept;
   logic     push_en;
   char_type ch;
   kind_type open_k;
   kind_type close_k;
   kind_type top_kind;

   // output register frees when empty or being taken
   assign req_ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && req_ready;
   assign ch        = req_chan.character;
   assign open_k    = open_kind(ch);
   assign close_k   = close_kind(ch);

   // top of stack: forwarded if pushed last cycle, else from memory read
   assign top_kind = fwd_ff ? fwd_kind_ff : rd_kind_ff;

   // next state of the stack and the verdict
   always_comb begin
      depth_in      = depth_ff;
      error_in      = error_ff;
      push_en       = 1'b0;
      fwd_in        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_reason_in = rsp_reason_ff;
      if (accept) begin
         if (ch == CHAR_END) begin
            rsp_valid_in = 1'b1;
            if (error_ff != REASON_OK) begin
               rsp_reason_in = error_ff;
            end else if (depth_ff != '0) begin
               rsp_reason_in = REASON_UNCLOSED;
            end else begin
               rsp_reason_in = REASON_OK;
            end
            depth_in = '0;
            error_in = REASON_OK;
         end else if (error_ff == REASON_OK) begin
            if (open_k != KIND_NONE) begin
               if (depth_ff == CNT_W'(STACK_DEPTH)) begin
                  error_in = REASON_OVERFLOW;
               end else begin
                  push_en  = 1'b1;
                  fwd_in   = 1'b1;
                  depth_in = depth_ff + CNT_W'(1);
               end
            end else if (close_k != KIND_NONE) begin
               if (depth_ff == '0) begin
                  error_in = REASON_EMPTY;
               end else begin
                  depth_in = depth_ff - CNT_W'(1);
                  if (top_kind != close_k) begin
                     error_in = REASON_MISMATCH;
                  end
               end
            end
         end
      end
   end

   // read address of the next top entry
   assign depth_dec = depth_in - CNT_W'(1);
   assign rd_addr   = depth_dec[ADDR_W-1:0];

   // stack memory: write on push, read next top every cycle
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[depth_ff[ADDR_W-1:0]] <= open_k;
      end
      rd_kind_ff <= stack_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         error_ff     <= REASON_OK;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         error_ff     <= error_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fwd_kind_ff   <= open_k;
      rsp_reason_ff <= rsp_reason_in;
   end

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.reason   = rsp_reason_ff;
   assign rsp_chan.balanced = (rsp_reason_ff == REASON_OK);

endmodule

`default_nettype wire

[hdl/bbc_checker.sv]
// bbc_checker: port-level assertions for the bracket balance checker, with its bind
// depends on bbc_pkg and the top level bracket_balance_checker
`default_nettype none

module bbc_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire [bbc_pkg::CHAR_W-1:0]    req_character,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire                          rsp_balanced,
   input wire [bbc_pkg::REASON_W-1:0]  rsp_reason
);
   import bbc_pkg::*;

   // balanced flag agrees with the reason code
   a_balanced_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_balanced == (rsp_reason == REASON_OK)))
      else $error("balanced flag disagrees with reason");

   // reason is a defined code
   a_reason_defined: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reason == REASON_OK || rsp_reason == REASON_EMPTY ||
                     rsp_reason == REASON_MISMATCH || rsp_reason == REASON_UNCLOSED ||
                     rsp_reason == REASON_OVERFLOW))
      else $error("undefined reason code");

   // end-of-string transfer gives a verdict in the next cycle
   a_verdict_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_character == CHAR_END) |=> rsp_valid)
      else $error("verdict missing after end of string");

   // a stalled verdict holds its value
   a_verdict_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_reason)))
      else $error("stalled verdict changed");

   // no byte taken while a verdict is stuck
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("byte taken while verdict stalled");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_character (req_chan.character),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_balanced  (rsp_chan.balanced),
   .rsp_reason    (rsp_chan.reason)
);

`default_nettype wire

[sim/bracket_balance_checker_test.sv]
// bracket_balance_checker_test: self-checking testbench for the bracket balance checker
// depends on bbc_pkg, the channel interfaces in bbc_channels.sv and bracket_balance_checker
`timescale 1ns / 1ps

module bracket_balance_checker_test;
   import bbc_pkg::*;

   localparam int STACK_DEPTH   = DEFAULT_STACK_DEPTH;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 550;
   localparam int PHASE_ITEMS   = 160;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct packed {
      logic       balanced;
      reason_type reason;
   } verdict_type;

   logic clock;
   logic reset;

   bbc_req_if req_chan ();
   bbc_rsp_if rsp_chan ();

   bracket_balance_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // predicted checker state
   kind_type    kind_stack [STACK_DEPTH];
   int unsigned stack_fill;
   reason_type  first_error;

   verdict_type pending_verdicts[$];
   int          error_count = 0;
   int          cycle_count = 0;

   // sender pacing
   int gap_pct;
   int max_gap;
   int burst_left;

   // receiver stall pattern
   int stall_pct;
   int hold_left = 0;
   bit ready_level = 1'b1;

   int bracket_items;

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bracket_balance_checker test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // advance the predicted state by one byte; a zero byte yields a verdict
   task automatic predict_char(input char_type c);
      verdict_type v;
      kind_type    k;
      bit          opening;
      bit          closing;
      opening = 1'b0;
      closing = 1'b0;
      k = KIND_NONE;
      case (c)
         CHAR_OPEN_RND: begin
            opening = 1'b1;
            k = KIND_ROUND;
         end
         CHAR_OPEN_SQR: begin
            opening = 1'b1;
            k = KIND_SQUARE;
         end
         CHAR_OPEN_CRL: begin
            opening = 1'b1;
            k = KIND_CURLY;
         end
         CHAR_CLOSE_RND: begin
            closing = 1'b1;
            k = KIND_ROUND;
         end
         CHAR_CLOSE_SQR: begin
            closing = 1'b1;
            k = KIND_SQUARE;
         end
         CHAR_CLOSE_CRL: begin
            closing = 1'b1;
            k = KIND_CURLY;
         end
         default: ;
      endcase

      if (c == CHAR_END) begin
         v.reason = first_error;
         if (v.reason == REASON_OK && stack_fill != 0) v.reason = REASON_UNCLOSED;
         v.balanced = (v.reason == REASON_OK);
         pending_verdicts.push_back(v);
         stack_fill  = 0;
         first_error = REASON_OK;
      end else if (first_error == REASON_OK) begin
         if (opening) begin
            if (stack_fill >= STACK_DEPTH) begin
               first_error = REASON_OVERFLOW;
            end else begin
               kind_stack[stack_fill] = k;
               stack_fill++;
            end
         end else if (closing) begin
            if (stack_fill == 0) begin
               first_error = REASON_EMPTY;
            end else begin
               stack_fill--;
               if (kind_stack[stack_fill] != k) first_error = REASON_MISMATCH;
            end
         end
      end
   endtask

   function automatic char_type open_char(input kind_type k);
      case (k)
         KIND_ROUND:  return CHAR_OPEN_RND;
         KIND_SQUARE: return CHAR_OPEN_SQR;
         default:     return CHAR_OPEN_CRL;
      endcase
   endfunction

   function automatic char_type close_char(input kind_type k);
      case (k)
         KIND_ROUND:  return CHAR_CLOSE_RND;
         KIND_SQUARE: return CHAR_CLOSE_SQR;
         default:     return CHAR_CLOSE_CRL;
      endcase
   endfunction

   // one byte transfer, with bursts and random gaps; called at a rising edge
   task automatic send_char(input char_type c);
      if (burst_left == 0) begin
         if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_chan.valid     <= 1'b1;
      req_chan.character <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_char(c);
      burst_left--;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(char_type'(s[i]));
      send_char(CHAR_END);
   endtask

   task automatic set_pacing(input int gp, input int mg, input int sp);
      gap_pct   = gp;
      max_gap   = mg;
      stall_pct = sp;
   endtask

   // receiver: stall pattern and verdict check
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict balanced=%0b reason=%0d with none pending",
                                      rsp_chan.balanced, rsp_chan.reason));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_chan.balanced !== want.balanced)
               report_mismatch($sformatf("balanced %0b, expected %0b",
                                         rsp_chan.balanced, want.balanced));
            if (rsp_chan.reason !== want.reason)
               report_mismatch($sformatf("reason %0d, expected %0d",
                                         rsp_chan.reason, want.reason));
         end
      end
      if (hold_left == 0) begin
         ready_level = ($urandom_range(99) >= stall_pct);
         hold_left   = $urandom_range(1, 6);
      end else begin
         hold_left--;
      end
      rsp_chan.ready <= ready_level;
   end

   // extremes of the byte, every bracket, the empty, mismatch and unclosed reasons
   task automatic test_directed();
      set_pacing(0, 1, 0);
      send_text("([{}])");
      send_text(")");
      send_text("(]");
      send_text("((");
      // bytes after an error are ignored, even closing ones
      send_text(")(()");
      send_char(CHAR_END);
      // non-bracket bytes between brackets
      send_char(8'hFF);
      send_char(CHAR_OPEN_SQR);
      send_char(8'h01);
      send_char(8'h80);
      send_char(8'h7F);
      send_char(CHAR_CLOSE_SQR);
      send_char(CHAR_END);
   endtask

   // stack filled to capacity, and one push beyond it
   task automatic test_stack_limits();
      set_pacing(20, 4, 20);
      for (int i = 0; i < STACK_DEPTH; i++) send_char(CHAR_OPEN_CRL);
      send_char(CHAR_END);
      for (int i = 0; i < STACK_DEPTH; i++) send_char(open_char(kind_type'(i % 3)));
      for (int i = STACK_DEPTH - 1; i >= 0; i--) send_char(close_char(kind_type'(i % 3)));
      send_char(CHAR_END);
      for (int i = 0; i <= STACK_DEPTH; i++) send_char(open_char(kind_type'(i % 3)));
      send_char(CHAR_CLOSE_RND);
      send_char(CHAR_END);
   endtask

   // mostly well-formed strings with noise; some unclosed, mismatched or empty closes
   task automatic send_random_string();
      kind_type open_stack[$];
      kind_type k;
      char_type c;
      int       style;
      int       length;
      int       depth_cap;
      style     = $urandom_range(99);
      length    = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 16);
      depth_cap = ($urandom_range(19) == 0) ? STACK_DEPTH + 2 : 12;
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(4) == 0) begin
            do c = char_type'($urandom_range(1, 255));
            while (style < 60 && (c inside {CHAR_OPEN_RND, CHAR_OPEN_SQR, CHAR_OPEN_CRL,
                                            CHAR_CLOSE_RND, CHAR_CLOSE_SQR, CHAR_CLOSE_CRL}));
            send_char(c);
            bracket_items++;
         end else if (open_stack.size() > 0 &&
                      (open_stack.size() >= depth_cap || $urandom_range(1) == 0)) begin
            k = open_stack.pop_back();
            if (style >= 80 && $urandom_range(7) == 0)
               k = (k == KIND_CURLY) ? KIND_ROUND : kind_type'(k + 1);
            send_char(close_char(k));
            bracket_items++;
         end else if (style >= 70 && style < 80 && open_stack.size() == 0 &&
                      $urandom_range(3) == 0) begin
            send_char(close_char(kind_type'($urandom_range(2))));
            bracket_items++;
         end else begin
            k = kind_type'($urandom_range(2));
            open_stack.push_back(k);
            send_char(open_char(k));
            bracket_items++;
         end
      end
      if (style < 60) begin
         while (open_stack.size() > 0) begin
            send_char(close_char(open_stack.pop_back()));
            bracket_items++;
         end
      end
      send_char(CHAR_END);
      bracket_items++;
   endtask

   task automatic test_random();
      int phase;
      phase = 0;
      bracket_items = 0;
      while (bracket_items < RANDOM_ITEMS) begin
         case (phase % 4)
            0: set_pacing(0, 1, 0);
            1: set_pacing(30, 3, 25);
            2: set_pacing(10, 2, 70);
            default: set_pacing(60, 8, 40);
         endcase
         while (bracket_items < (phase + 1) * PHASE_ITEMS && bracket_items < RANDOM_ITEMS)
            send_random_string();
         phase++;
      end
   endtask

   // stimulus and end of run
   initial begin
      stack_fill  = 0;
      first_error = REASON_OK;
      burst_left  = 0;
      set_pacing(0, 1, 0);
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.character <= CHAR_END;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_stack_limits();
      test_random();

      req_chan.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("bracket_balance_checker test passed");
      end else begin
         $display("bracket_balance_checker test failed");
      end
      $finish;
   end

endmodule
